// ===== rtl/core/tkpd_pkg.sv =====
// Package for the two-kind packet deframer.
// Holds the frame phase type, result kind codes and register indexes.
// No dependencies.
package tkpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_D1     = 3'd1,
    PH_D2     = 3'd2,
    PH_CLASS  = 3'd3,
    PH_CONF   = 3'd4
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_SAMPLE     = 2'd0;
  localparam kind_t KIND_PREDICTION = 2'd1;
  localparam kind_t KIND_ERROR      = 2'd2;

  localparam int unsigned REG_ADDR_W = 4;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_SAMPLE_HDR  = 2'd0;
  localparam reg_idx_t REG_PREDICT_HDR = 2'd1;
  localparam reg_idx_t REG_TIMEOUT     = 2'd2;
  localparam reg_idx_t REG_CLASS_COUNT = 2'd3;

  localparam logic [7:0]  RST_SAMPLE_HDR  = 8'd170;
  localparam logic [7:0]  RST_PREDICT_HDR = 8'd187;
  localparam logic [15:0] RST_TIMEOUT     = 16'd100;
  localparam logic [8:0]  RST_CLASS_COUNT = 9'd4;

  localparam logic [16:0] SILENCE_MAX = 17'h1FFFF;
  localparam logic [3:0]  LOW_NIBBLE  = 4'hF;

endpackage

// ===== rtl/core/tkpd_if.sv =====
// Word channels of the deframer: byte/tick input and packet result output.
// Each carries valid, ready and the payload. Depends on tkpd_pkg.
interface tkpd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface tkpd_out_if import tkpd_pkg::*; ;
  logic        valid;
  logic        ready;
  kind_t       packet_kind;
  logic [11:0] sample_value;
  logic [31:0] sample_sequence;
  logic [7:0]  class_code;
  logic [7:0]  confidence_byte;
  logic [31:0] error_count;
  logic [31:0] packet_count;

  modport source (
    output valid, output packet_kind, output sample_value, output sample_sequence,
    output class_code, output confidence_byte, output error_count, output packet_count,
    input ready
  );
  modport sink (
    input valid, input packet_kind, input sample_value, input sample_sequence,
    input class_code, input confidence_byte, input error_count, input packet_count,
    output ready
  );
endinterface

// ===== rtl/core/two_kind_packet_deframer_unit.sv =====
// Two-kind packet deframer: top level with APB register port.
// Output: a result word appears in the output register in the cycle after the
// word that completes (or breaks) a packet is accepted.
// Throughput: one input word per cycle; the input stalls only while a result
// sits in the output register and the sink holds ready low.
// Reset (rst, synchronous): header wait, counters cleared, registers to defaults.
module two_kind_packet_deframer_unit import tkpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  tkpd_in_if.sink               in_ch,
  tkpd_out_if.source            out_ch
);

  logic [7:0]  sample_header;
  logic [7:0]  prediction_header;
  logic [15:0] timeout_ticks;
  logic [8:0]  class_count;

  phase_t      phase, phase_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [16:0] silence_ticks, silence_ticks_next;
  logic [31:0] sequence_counter, sequence_counter_next;
  logic [31:0] error_counter, error_counter_next;
  logic [31:0] good_counter, good_counter_next;

  logic        in_acc;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [16:0] silence_inc;
  logic        timeout_hit;
  logic [7:0]  b;
  logic        res_valid;
  kind_t       res_kind;
  logic [11:0] res_value;
  logic [31:0] res_seq;
  logic [7:0]  res_class;
  logic [7:0]  res_conf;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[REG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_header     <= RST_SAMPLE_HDR;
      prediction_header <= RST_PREDICT_HDR;
      timeout_ticks     <= RST_TIMEOUT;
      class_count       <= RST_CLASS_COUNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SAMPLE_HDR:  sample_header     <= pwdata[7:0];
        REG_PREDICT_HDR: prediction_header <= pwdata[7:0];
        REG_TIMEOUT:     timeout_ticks     <= pwdata[15:0];
        REG_CLASS_COUNT: class_count       <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SAMPLE_HDR:  prdata = {24'd0, sample_header};
      REG_PREDICT_HDR: prdata = {24'd0, prediction_header};
      REG_TIMEOUT:     prdata = {16'd0, timeout_ticks};
      REG_CLASS_COUNT: prdata = {23'd0, class_count};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- input handshake ----------------
  assign in_ch.ready = ~out_ch.valid | out_ch.ready;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign b           = in_ch.data_byte;

  assign silence_inc = (silence_ticks == SILENCE_MAX) ? silence_ticks
                                                      : silence_ticks + 17'd1;
  assign timeout_hit = silence_inc > {1'b0, timeout_ticks};

  // ---------------- next phase ----------------
  always_comb begin
    phase_next = phase;
    if (in_acc) begin
      if (!in_ch.operation) begin
        if (phase != PH_HEADER && timeout_hit) phase_next = PH_HEADER;
      end else begin
        unique case (phase)
          PH_D1:    phase_next = PH_D2;
          PH_D2:    phase_next = PH_HEADER;
          PH_CLASS: phase_next = PH_CONF;
          PH_CONF:  phase_next = PH_HEADER;
          default: begin
            // equal headers: sample packet wins
            if (b == sample_header)          phase_next = PH_D1;
            else if (b == prediction_header) phase_next = PH_CLASS;
            else                             phase_next = PH_HEADER;
          end
        endcase
      end
    end
  end

  // ---------------- datapath and result ----------------
  always_comb begin
    held_byte_next        = held_byte;
    silence_ticks_next    = silence_ticks;
    sequence_counter_next = sequence_counter;
    error_counter_next    = error_counter;
    good_counter_next     = good_counter;
    res_valid             = 1'b0;
    res_kind              = KIND_ERROR;
    res_value             = 12'd0;
    res_seq               = 32'd0;
    res_class             = 8'd0;
    res_conf              = 8'd0;
    if (in_acc) begin
      if (!in_ch.operation) begin
        if (phase != PH_HEADER) begin
          if (timeout_hit) begin
            silence_ticks_next = 17'd0;
            error_counter_next = error_counter + 32'd1;
            res_valid          = 1'b1;
          end else begin
            silence_ticks_next = silence_inc;
          end
        end
      end else begin
        silence_ticks_next = 17'd0;
        unique case (phase)
          PH_D1, PH_CLASS: held_byte_next = b;
          PH_D2: begin
            res_valid = 1'b1;
            if ((b[3:0] & LOW_NIBBLE) != 4'd0) begin
              error_counter_next = error_counter + 32'd1;
            end else begin
              res_kind              = KIND_SAMPLE;
              res_value             = {held_byte, b[7:4]};
              res_seq               = sequence_counter;
              sequence_counter_next = sequence_counter + 32'd1;
              good_counter_next     = good_counter + 32'd1;
            end
          end
          PH_CONF: begin
            res_valid = 1'b1;
            if ({1'b0, held_byte} >= class_count) begin
              error_counter_next = error_counter + 32'd1;
            end else begin
              res_kind          = KIND_PREDICTION;
              res_class         = held_byte;
              res_conf          = b;
              good_counter_next = good_counter + 32'd1;
            end
          end
          default: begin
            // header wait: silence only restarts on a header match
            if (b != sample_header && b != prediction_header)
              silence_ticks_next = silence_ticks;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      held_byte        <= 8'd0;
      silence_ticks    <= 17'd0;
      sequence_counter <= 32'd0;
      error_counter    <= 32'd0;
      good_counter     <= 32'd0;
    end else begin
      phase            <= phase_next;
      held_byte        <= held_byte_next;
      silence_ticks    <= silence_ticks_next;
      sequence_counter <= sequence_counter_next;
      error_counter    <= error_counter_next;
      good_counter     <= good_counter_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_acc) begin
      out_ch.valid <= res_valid;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_ch.packet_kind     <= res_kind;
      out_ch.sample_value    <= res_value;
      out_ch.sample_sequence <= res_seq;
      out_ch.class_code      <= res_class;
      out_ch.confidence_byte <= res_conf;
      out_ch.error_count     <= error_counter_next;
      out_ch.packet_count    <= good_counter_next;
    end
  end

  // ---------------- assertions ----------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && out_ch.valid && !out_ch.ready))
    else $error("input taken while a result is stalled");

  a_idle_silence: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> silence_ticks == 17'd0)
    else $error("silence count running during header wait");

  a_err_with_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && error_counter_next != error_counter |=>
      out_ch.valid && out_ch.packet_kind == KIND_ERROR && phase == PH_HEADER)
    else $error("error count moved without an error word");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.packet_kind == KIND_SAMPLE |->
      out_ch.class_code == 8'd0 && out_ch.confidence_byte == 8'd0)
    else $error("sample word carries prediction fields");

  a_good_count: assert property (@(posedge clk) disable iff (rst)
    in_acc && res_valid && res_kind != KIND_ERROR |=>
      good_counter == $past(good_counter) + 32'd1)
    else $error("packet count not advanced on a good packet");

endmodule
